// File: rtl/core/sgmpca_pkg.sv
// sgmpca_pkg: shared widths, register indexes and divider command type
// for the SGM path cost aggregation block. No dependencies.
`timescale 1ns / 1ps

package sgmpca_pkg;

  localparam int COST_W  = 8;
  localparam int GRAY_W  = 8;
  localparam int SUM_W   = 16;
  localparam int DIDX_W  = 6;
  localparam int P1_W    = 8;
  localparam int P2_W    = 16;
  localparam int DCNT_W  = 7;

  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;

  localparam logic [CFG_AW-1:0] REG_SMALL_PENALTY = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LARGE_PENALTY = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DISP_COUNT    = 2'd2;

  // divider: 16-bit dividend, divisor is gray difference plus one (1..256)
  localparam int DIV_NW  = 16;
  localparam int DIV_DW  = 9;

  localparam logic [COST_W-1:0] COST_MAX = 8'hFF;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_cmd_t;

endpackage

// File: rtl/core/sgmpca_div.sv
// sgmpca_div: restoring divider, one quotient bit per cycle.
// Uses sgmpca_pkg for widths and the command struct.
`timescale 1ns / 1ps

module sgmpca_div import sgmpca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_cmd_t          cmd,
  output logic [DIV_NW-1:0] quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-2:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] dvs;

  logic [DIV_DW-1:0] shifted;
  logic              ge;
  logic [DIV_DW-1:0] rem_next;

  // remainder stays below the divisor, so it fits one bit narrower
  assign shifted  = {rem, quo[DIV_NW-1]};
  assign ge       = (shifted >= dvs);
  assign rem_next = ge ? (shifted - dvs) : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= '0;
      quo <= cmd.dividend;
      dvs <= cmd.divisor;
    end else if (busy) begin
      rem <= rem_next[DIV_DW-2:0];
      quo <= {quo[DIV_NW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/core/sgm_path_cost_aggregation.sv
// Channel   | Dir | Fields (low bit up)                                    | Transfer when
// s_axis    | in  | tuser: first_of_path; tdata: disparity_index, gray,    | tvalid & tready
//           |     |   match_cost, sum_in, 2 pad bits                       |
// m_axis    | out | tdata: path_cost, sum_out                              | tvalid & tready
// cfg       | in  | cfg_addr selects register, cfg_wdata holds value       | cfg_we
//
// Flow: a first-of-path item goes straight to write-back; other items pass RD,
// RD2, RD3, the 16-step serial divider unless the gray difference matches the
// cached division, then CALC and WB. Path costs live in one RAM of two banks,
// MAX_DISP entries each; three reads of the previous row use two read ports.
// Reset: synchronous; a clearing pass over all MAX_DISP entries fills bank 0
// with 255 while s_axis_tready is low. Configuration writes are taken as ever.
// Stalls: the output register holds one result; write-back waits for it.
// Depends on sgmpca_pkg and sgmpca_div.
`timescale 1ns / 1ps

module sgm_path_cost_aggregation import sgmpca_pkg::*; #(
  parameter int MAX_DISP = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: [5:0] disparity_index, [13:6] gray_value, [21:14] match_cost,
  //        [37:22] sum_in, [39:38] zero
  input  logic [39:0]       s_axis_tdata,
  // tuser: [0] first_of_path
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: [7:0] path_cost, [23:8] sum_out
  output logic [23:0]       m_axis_tdata
);

  localparam int DW  = (MAX_DISP > 1) ? $clog2(MAX_DISP) : 1;
  localparam int AW  = $clog2(2 * MAX_DISP);
  localparam int XW  = ($clog2(MAX_DISP + 2) > 7) ? $clog2(MAX_DISP + 2) : 7;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_DISP);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_RD3   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_CALC  = 3'd6;
  localparam logic [2:0] S_WB    = 3'd7;

  logic [2:0] state;

  // configuration
  logic [P1_W-1:0]   p1;
  logic [P2_W-1:0]   p2;
  logic [DCNT_W-1:0] dcount;
  logic [XW-1:0]     dc_x;
  logic [XW-1:0]     cnt_eff;

  // item being worked on
  logic              it_first;
  logic [DIDX_W-1:0] it_d;
  logic [GRAY_W-1:0] it_gray;
  logic [COST_W-1:0] it_cost;
  logic [SUM_W-1:0]  it_sum;

  logic [COST_W-1:0] prev_min;
  logic [COST_W-1:0] run_min;
  logic [GRAY_W-1:0] prev_gray;
  logic [GRAY_W-1:0] cur_gray;
  logic [GRAY_W-1:0] gdiff;

  // per entry: bank holding the current row, and written since last pixel
  logic [MAX_DISP-1:0] cur_sel;
  logic [MAX_DISP-1:0] wr_flag;

  logic [COST_W-1:0] mem [2*MAX_DISP];
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [COST_W-1:0] rd_a;
  logic [COST_W-1:0] rd_b;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [COST_W-1:0] mem_wdata;
  logic [DW-1:0]     clr_idx;

  logic [COST_W-1:0] lp_m1;
  logic [COST_W-1:0] lp_0;
  logic [COST_W-1:0] lp_p1;
  logic [COST_W-1:0] res;

  logic              div_ok;
  logic [GRAY_W-1:0] div_gd;
  logic [DIV_NW-1:0] div_q;
  logic [DIV_NW-1:0] div_quo;
  logic              div_done;
  div_cmd_t          div_cmd;

  logic              out_valid;
  logic [COST_W-1:0] out_pc;
  logic [SUM_W-1:0]  out_sum;

  logic              in_xfer;
  logic              out_free;

  logic [XW-1:0] d_x, km1, kp1;
  logic          v_m1, v_0, v_p1, d_in_mem;
  logic [DW-1:0] i_m1, i_0, i_p1, i_wb;
  logic          wbank;

  function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [DW-1:0] idx);
    logic [AW-1:0] a;
    a = AW'(idx);
    if (bank) a = a + AW'(MAX_DISP);
    return a;
  endfunction

  assign dc_x    = XW'(dcount);
  assign cnt_eff = (dc_x == '0) ? XW'(1) : ((dc_x > MAX_X) ? MAX_X : dc_x);

  assign d_x      = XW'(it_d);
  assign km1      = d_x - XW'(1);
  assign kp1      = d_x + XW'(1);
  assign v_m1     = (it_d != '0) && (km1 < cnt_eff);
  assign v_0      = d_x < cnt_eff;
  assign v_p1     = kp1 < cnt_eff;
  assign d_in_mem = d_x < MAX_X;

  // neighbours outside the range read index 0, which keeps reads in bounds; their values are not used
  assign i_m1 = v_m1 ? km1[DW-1:0] : '0;
  assign i_0  = v_0 ? d_x[DW-1:0] : '0;
  assign i_p1 = v_p1 ? kp1[DW-1:0] : '0;
  assign i_wb = d_in_mem ? d_x[DW-1:0] : '0;

  // an untouched entry shares its bank with the previous row: write the other one
  assign wbank = wr_flag[i_wb] ? cur_sel[i_wb] : ~cur_sel[i_wb];

  assign rd_addr_a = (state == S_RD2) ? bank_addr(wr_flag[i_p1] ^ cur_sel[i_p1], i_p1)
                                      : bank_addr(wr_flag[i_m1] ^ cur_sel[i_m1], i_m1);
  assign rd_addr_b = bank_addr(wr_flag[i_0] ^ cur_sel[i_0], i_0);

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // writes happen only in clear and write-back, never beside a read in flight
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bank_addr(wbank, i_wb);
    mem_wdata = res;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = bank_addr(1'b0, clr_idx);
      mem_wdata = COST_MAX;
    end else if (state == S_WB && out_free && d_in_mem) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_comb begin
    div_cmd.start    = (state == S_RD3) && !(div_ok && (div_gd == gdiff));
    div_cmd.dividend = p2;
    div_cmd.divisor  = DIV_DW'(gdiff) + DIV_DW'(1);
  end

  sgmpca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1     <= P1_W'(10);
      p2     <= P2_W'(150);
      dcount <= DCNT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SMALL_PENALTY: p1     <= cfg_wdata[P1_W-1:0];
        REG_LARGE_PENALTY: p2     <= cfg_wdata[P2_W-1:0];
        REG_DISP_COUNT:    dcount <= cfg_wdata[DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [8:0]        l1, l2, l3;
  logic [DIV_NW-1:0] jump;
  logic [16:0]       l4, best;

  always_comb begin
    l1   = v_0 ? {1'b0, lp_0} : {1'b0, COST_MAX};
    l2   = (v_m1 ? {1'b0, lp_m1} : {1'b0, COST_MAX}) + 9'(p1);
    l3   = (v_p1 ? {1'b0, lp_p1} : {1'b0, COST_MAX}) + 9'(p1);
    jump = (div_q < DIV_NW'(p1)) ? DIV_NW'(p1) : div_q;
    l4   = 17'(prev_min) + 17'(jump);
    best = 17'(l1);
    if (17'(l2) < best) best = 17'(l2);
    if (17'(l3) < best) best = 17'(l3);
    if (l4 < best) best = l4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      cur_sel   <= '0;
      wr_flag   <= '0;
      prev_min  <= COST_MAX;
      run_min   <= COST_MAX;
      prev_gray <= '0;
      cur_gray  <= '0;
      div_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) div_ok <= 1'b0;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == DW'(MAX_DISP - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) begin
            // a new pixel: current row becomes previous row
            if (s_axis_tdata[5:0] == '0) begin
              wr_flag   <= '0;
              prev_min  <= run_min;
              prev_gray <= cur_gray;
              run_min   <= COST_MAX;
            end
            state <= s_axis_tuser ? S_WB : S_RD;
          end
        end
        S_RD:  state <= S_RD2;
        S_RD2: state <= S_RD3;
        S_RD3: state <= div_cmd.start ? S_DIV : S_CALC;
        S_DIV: begin
          if (div_done) begin
            div_ok <= !cfg_we;
            state  <= S_CALC;
          end
        end
        S_CALC: state <= S_WB;
        S_WB: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (d_in_mem) begin
              cur_sel[i_wb] <= wbank;
              wr_flag[i_wb] <= 1'b1;
            end
            if (res < run_min) run_min <= res;
            cur_gray <= it_gray;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_first <= s_axis_tuser;
      it_d     <= s_axis_tdata[5:0];
      it_gray  <= s_axis_tdata[13:6];
      it_cost  <= s_axis_tdata[21:14];
      it_sum   <= s_axis_tdata[37:22];
      res      <= s_axis_tdata[21:14];
    end
    if (state == S_RD) gdiff <= (it_gray > prev_gray) ? (it_gray - prev_gray)
                                                      : (prev_gray - it_gray);
    if (state == S_RD2) begin
      lp_m1 <= rd_a;
      lp_0  <= rd_b;
    end
    if (state == S_RD3) lp_p1 <= rd_a;
    if (state == S_DIV && div_done) begin
      div_q  <= div_quo;
      div_gd <= gdiff;
    end
    if (state == S_CALC) res <= it_cost + best[COST_W-1:0] - prev_min;
    if (state == S_WB && out_free) begin
      out_pc  <= res;
      out_sum <= it_sum + SUM_W'(res);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_sum, out_pc};

`ifndef ASSERT_OFF
  a_out_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_WB)
    else $error("result shown without a write-back");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_RD && !it_first) || (state == S_WB && it_first))
    else $error("accepted item took the wrong path");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_CLEAR || (state == S_WB && out_free))
    else $error("cost RAM written outside clear or write-back");
`endif

endmodule
